[design/ohtab_pkg.sv]
package ohtab_pkg;

  localparam int TABLE_SIZE_DEF = 16;
  localparam int KEY_W          = 32;
  localparam int SLOT_W         = 4;
  localparam int STATUS_W       = 2;
  localparam int ENTRY_W        = STATUS_W + KEY_W;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int COEF_W         = 8;
  localparam int SLOT_MAX_W     = 12;
  localparam int COEF_MAX_W     = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OCC   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DEL   = 2'd2;

  localparam logic [1:0] PM_LINEAR = 2'd0;
  localparam logic [1:0] PM_QUAD   = 2'd1;
  localparam logic [1:0] PM_DOUBLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_LIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_SQ    = 2'd2;

  typedef struct packed {
    cmd_t                  cmd;
    logic [KEY_W-1:0]      key;
    logic [SLOT_MAX_W-1:0] h1;
    logic [SLOT_MAX_W-1:0] step;
    logic [COEF_MAX_W-1:0] c1m;
    logic [COEF_MAX_W-1:0] c2m;
    logic [COEF_MAX_W-1:0] c2x2;
  } job_t;

endpackage

[design/ohtab_ram.sv]
module ohtab_ram #(
  parameter int WIDTH = ohtab_pkg::ENTRY_W,
  parameter int DEPTH = ohtab_pkg::TABLE_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[design/ohtab_fifo.sv]
module ohtab_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ohtab_pkg::job_t  push_job,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output ohtab_pkg::job_t  head
);

  import ohtab_pkg::*;

  localparam int DEPTH = 2;

  job_t       mem_r [DEPTH];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign full       = count_r == 2'(DEPTH);
  assign head_valid = count_r != 2'd0;
  assign head       = mem_r[rp_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        mem_r[wp_r] <= push_job;
        wp_r        <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

[design/ohtab_front.sv]
module ohtab_front #(
  parameter int TABLE_SIZE = ohtab_pkg::TABLE_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               hold,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_command,
  input  logic signed [ohtab_pkg::KEY_W-1:0] in_key,
  input  logic [ohtab_pkg::COEF_W-1:0]       quad_linear_coeff,
  input  logic [ohtab_pkg::COEF_W-1:0]       quad_square_coeff,
  output logic                               job_push,
  output ohtab_pkg::job_t                    job,
  input  logic                               job_full
);

  import ohtab_pkg::*;

  localparam int DW    = $clog2(16 * TABLE_SIZE) + 1;
  localparam int STEPS = 4;
  localparam int NCYC  = KEY_W / STEPS;
  localparam int CNT_W = $clog2(NCYC);
  localparam logic [DW-1:0]    DIV_M    = DW'(TABLE_SIZE);
  localparam logic [DW-1:0]    DIV_S    = DW'(TABLE_SIZE - 1);
  localparam logic [DW-1:0]    DIV_Q    = DW'(16 * TABLE_SIZE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NCYC - 1);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic             neg_r;
  logic [KEY_W-1:0] kd_r;
  logic [KEY_W-1:0] c1d_r;
  logic [KEY_W-1:0] c2d_r;
  logic [DW-1:0]    rem_m_r;
  logic [DW-1:0]    rem_s_r;
  logic [DW-1:0]    rem_1_r;
  logic [DW-1:0]    rem_2_r;

  logic [DW-1:0]    rem_m_nxt;
  logic [DW-1:0]    rem_s_nxt;
  logic [DW-1:0]    rem_1_nxt;
  logic [DW-1:0]    rem_2_nxt;
  logic [KEY_W-1:0] key_u;
  logic [DW-1:0]    h1_w;
  logic [DW-1:0]    step_w;
  logic [DW:0]      dbl_w;
  logic [DW-1:0]    c2x2_w;
  logic             accept;

  function automatic logic [DW-1:0] rstep(input logic [DW-1:0] rem, input logic b,
                                           input logic [DW-1:0] d);
    logic [DW:0] t;
    t = {rem, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[DW-1:0];
  endfunction

  assign in_stall = (state_r != F_IDLE) || hold;
  assign accept   = in_valid && !in_stall;
  assign key_u    = in_key;

  always_comb begin
    rem_m_nxt = rem_m_r;
    rem_s_nxt = rem_s_r;
    rem_1_nxt = rem_1_r;
    rem_2_nxt = rem_2_r;
    for (int j = 0; j < STEPS; j++) begin
      rem_m_nxt = rstep(rem_m_nxt, kd_r[KEY_W-1-j], DIV_M);
      rem_s_nxt = rstep(rem_s_nxt, kd_r[KEY_W-1-j], DIV_S);
      rem_1_nxt = rstep(rem_1_nxt, c1d_r[KEY_W-1-j], DIV_Q);
      rem_2_nxt = rstep(rem_2_nxt, c2d_r[KEY_W-1-j], DIV_Q);
    end
  end

  always_comb begin
    h1_w   = (neg_r && rem_m_r != '0) ? DIV_M - rem_m_r : rem_m_r;
    step_w = ((neg_r && rem_s_r != '0) ? DIV_S - rem_s_r : rem_s_r) + DW'(1);
    dbl_w  = {rem_2_r, 1'b0};
    if (dbl_w >= {1'b0, DIV_Q}) begin
      dbl_w = dbl_w - {1'b0, DIV_Q};
    end
    c2x2_w = dbl_w[DW-1:0];
  end

  assign job_push  = (state_r == F_PUSH) && !job_full;
  assign job.cmd   = cmd_r;
  assign job.key   = key_r;
  assign job.h1    = SLOT_MAX_W'(h1_w);
  assign job.step  = SLOT_MAX_W'(step_w);
  assign job.c1m   = COEF_MAX_W'(rem_1_r);
  assign job.c2m   = COEF_MAX_W'(rem_2_r);
  assign job.c2x2  = COEF_MAX_W'(c2x2_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            cmd_r   <= cmd_t'(in_command);
            key_r   <= key_u;
            neg_r   <= key_u[KEY_W-1];
            kd_r    <= key_u[KEY_W-1] ? ~key_u + 32'd1 : key_u;
            c1d_r   <= {{(KEY_W-COEF_W){1'b0}}, quad_linear_coeff};
            c2d_r   <= {{(KEY_W-COEF_W){1'b0}}, quad_square_coeff};
            rem_m_r <= '0;
            rem_s_r <= '0;
            rem_1_r <= '0;
            rem_2_r <= '0;
            cnt_r   <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          rem_m_r <= rem_m_nxt;
          rem_s_r <= rem_s_nxt;
          rem_1_r <= rem_1_nxt;
          rem_2_r <= rem_2_nxt;
          kd_r    <= kd_r << STEPS;
          c1d_r   <= c1d_r << STEPS;
          c2d_r   <= c2d_r << STEPS;
          cnt_r   <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_LAST) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!job_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

[design/ohtab_back.sv]
module ohtab_back #(
  parameter int TABLE_SIZE = ohtab_pkg::TABLE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    probe_mode,
  input  logic                          job_valid,
  input  ohtab_pkg::job_t               job,
  output logic                          job_pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_success,
  output logic [ohtab_pkg::SLOT_W-1:0]  out_slot
);

  import ohtab_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int RW = $clog2(16 * TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [AW+1:0] M_S    = (AW+2)'(TABLE_SIZE);
  localparam logic [AW:0]   M_O    = (AW+1)'(TABLE_SIZE);
  localparam logic [RW:0]   Q_R    = (RW+1)'(16 * TABLE_SIZE);
  localparam logic [CW-1:0] M_C    = CW'(TABLE_SIZE);
  localparam logic [CW-1:0] LAST_C = CW'(TABLE_SIZE - 1);
  localparam logic [AW-1:0] LAST_A = AW'(TABLE_SIZE - 1);

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_PROBE, B_DONE} bstate_t;

  bstate_t          state_r;
  logic [AW-1:0]    clr_r;
  cmd_t             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [AW-1:0]    h1_r;
  logic [AW-1:0]    step_r;
  logic [RW-1:0]    c1m_r;
  logic [RW-1:0]    c2x2_r;
  logic [AW-1:0]    off_r;
  logic [RW-1:0]    qa_r;
  logic [RW-1:0]    qb_r;
  logic [RW-1:0]    qd_r;
  logic [CW-1:0]    iss_r;
  logic             rd_v_r;
  logic             rd_last_r;
  logic [AW-1:0]    rd_slot_r;
  logic             res_ok_r;
  logic [AW-1:0]    res_slot_r;
  logic             out_valid_r;
  logic             out_success_r;
  logic [SLOT_W-1:0] out_slot_r;

  logic [AW-1:0]    off_nxt;
  logic [RW-1:0]    qa_nxt;
  logic [RW-1:0]    qb_nxt;
  logic [RW-1:0]    qd_nxt;
  logic [AW:0]      off_sum;
  logic [AW-1:0]    x_w;
  logic [AW-1:0]    y_w;
  logic [AW+1:0]    idx_sum;
  logic [AW-1:0]    cur_idx;
  logic             issue;
  logic             hit;
  logic             miss;
  logic             finish;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [STATUS_W-1:0] rd_status;
  logic [KEY_W-1:0] rd_key;
  logic [AW+SLOT_W-1:0] slot_ext;

  function automatic logic [RW-1:0] addmod_q(input logic [RW-1:0] a, input logic [RW-1:0] b);
    logic [RW:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= Q_R) begin
      t = t - Q_R;
    end
    return t[RW-1:0];
  endfunction

  always_comb begin
    case (probe_mode) inside
      PM_LINEAR, PM_DOUBLE: begin
        x_w = off_r;
        y_w = '0;
      end
      PM_QUAD: begin
        x_w = qa_r[RW-1:4];
        y_w = qb_r[RW-1:4];
      end
      default: begin
        x_w = '0;
        y_w = '0;
      end
    endcase
    idx_sum = (AW+2)'(h1_r) + (AW+2)'(x_w) + (AW+2)'(y_w);
    if (idx_sum >= M_S) begin
      idx_sum = idx_sum - M_S;
    end
    if (idx_sum >= M_S) begin
      idx_sum = idx_sum - M_S;
    end
    cur_idx = idx_sum[AW-1:0];
  end

  always_comb begin
    off_sum = {1'b0, off_r} + {1'b0, (probe_mode == PM_DOUBLE) ? step_r : AW'(1)};
    if (off_sum >= M_O) begin
      off_sum = off_sum - M_O;
    end
    off_nxt = off_sum[AW-1:0];
    qa_nxt  = addmod_q(qa_r, c1m_r);
    qb_nxt  = addmod_q(qb_r, qd_r);
    qd_nxt  = addmod_q(qd_r, c2x2_r);
  end

  assign rd_status = ram_rdata[ENTRY_W-1:KEY_W];
  assign rd_key    = ram_rdata[KEY_W-1:0];

  always_comb begin
    hit  = 1'b0;
    miss = 1'b0;
    case (cmd_r) inside
      CMD_INSERT: hit = rd_status != ST_OCC;
      CMD_SEARCH, CMD_DELETE: begin
        miss = rd_status == ST_EMPTY;
        hit  = (rd_status == ST_OCC) && (rd_key == key_r);
      end
      default: miss = 1'b1;
    endcase
  end

  assign issue  = (state_r == B_PROBE) && (iss_r < M_C);
  assign finish = (state_r == B_PROBE) && rd_v_r && (hit || miss || rd_last_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = {ST_EMPTY, {KEY_W{1'b0}}};
    if (state_r == B_CLEAR) begin
      ram_we = 1'b1;
    end else if (finish && hit && cmd_r != CMD_SEARCH) begin
      ram_we    = 1'b1;
      ram_waddr = rd_slot_r;
      ram_wdata = {(cmd_r == CMD_DELETE) ? ST_DEL : ST_OCC, key_r};
    end
  end

  ohtab_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_idx),
    .rdata (ram_rdata)
  );

  assign job_pop     = (state_r == B_IDLE) && job_valid;
  assign clearing    = state_r == B_CLEAR;
  assign slot_ext    = {{SLOT_W{1'b0}}, res_slot_r};
  assign out_valid   = out_valid_r;
  assign out_success = out_success_r;
  assign out_slot    = out_slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == LAST_A) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (job_valid) begin
            cmd_r  <= job.cmd;
            key_r  <= job.key;
            h1_r   <= job.h1[AW-1:0];
            step_r <= job.step[AW-1:0];
            c1m_r  <= job.c1m[RW-1:0];
            c2x2_r <= job.c2x2[RW-1:0];
            qd_r   <= job.c2m[RW-1:0];
            off_r  <= '0;
            qa_r   <= '0;
            qb_r   <= '0;
            iss_r  <= '0;
            rd_v_r <= 1'b0;
            case (job.cmd) inside
              CMD_INSERT, CMD_SEARCH, CMD_DELETE: state_r <= B_PROBE;
              default: begin
                res_ok_r   <= 1'b0;
                res_slot_r <= '0;
                state_r    <= B_DONE;
              end
            endcase
          end
        end
        B_PROBE: begin
          if (issue) begin
            off_r <= off_nxt;
            qa_r  <= qa_nxt;
            qb_r  <= qb_nxt;
            qd_r  <= qd_nxt;
            iss_r <= iss_r + CW'(1);
          end
          rd_v_r    <= issue;
          rd_last_r <= iss_r == LAST_C;
          rd_slot_r <= cur_idx;
          if (finish) begin
            res_ok_r   <= hit;
            res_slot_r <= hit ? rd_slot_r : '0;
            state_r    <= B_DONE;
          end
        end
        B_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_success_r <= res_ok_r;
            out_slot_r    <= slot_ext[SLOT_W-1:0];
            state_r       <= B_IDLE;
          end
        end
        default: state_r <= B_CLEAR;
      endcase
    end
  end

endmodule

[design/open_addressing_hash_table.sv]
// Open-addressing hash table of signed 32-bit keys with deleted-slot markers.
// Request channel: in_valid/in_stall with in_command (insert, search, delete)
// and in_key. Result channel: out_valid/out_stall with out_success and
// out_slot, exactly one result per request, in request order.
// Configuration: cfg_we/cfg_index/cfg_wdata selects the probe sequence and
// the quadratic coefficients; write only while the block is idle.
// The front end takes a request, reduces the key modulo the table size and
// the probe step, and the quadratic coefficients modulo 16 * TABLE_SIZE, 4 bits
// a cycle, then queues it; it takes no new request until the current one is
// queued. The back end probes one slot per cycle through a registered-read
// table memory, at most TABLE_SIZE probes per request. Front and back overlap
// through a two-entry queue.
// After reset the table memory is swept to empty; in_stall stays high until
// the sweep is done.
// When out_stall is high the result holds in its output register; the back
// end may start the next request and waits only to hand over its result.
module open_addressing_hash_table #(
  parameter int TABLE_SIZE = ohtab_pkg::TABLE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_command,
  input  logic signed [ohtab_pkg::KEY_W-1:0]  in_key,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_success,
  output logic [ohtab_pkg::SLOT_W-1:0]        out_slot,
  input  logic                                cfg_we,
  input  logic [ohtab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ohtab_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import ohtab_pkg::*;

  logic [1:0]        probe_mode_r;
  logic [COEF_W-1:0] quad_lin_r;
  logic [COEF_W-1:0] quad_sq_r;

  job_t push_job;
  job_t head_job;
  logic job_push;
  logic job_full;
  logic job_pop;
  logic head_valid;
  logic clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_mode_r <= PM_LINEAR;
      quad_lin_r   <= 8'd8;
      quad_sq_r    <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROBE_MODE: probe_mode_r <= cfg_wdata[1:0];
        CFG_QUAD_LIN:   quad_lin_r   <= cfg_wdata[COEF_W-1:0];
        CFG_QUAD_SQ:    quad_sq_r    <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  ohtab_front #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .hold              (clearing),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_key            (in_key),
    .quad_linear_coeff (quad_lin_r),
    .quad_square_coeff (quad_sq_r),
    .job_push          (job_push),
    .job               (push_job),
    .job_full          (job_full)
  );

  ohtab_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (job_push),
    .push_job   (push_job),
    .full       (job_full),
    .pop        (job_pop),
    .head_valid (head_valid),
    .head       (head_job)
  );

  ohtab_back #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .probe_mode  (probe_mode_r),
    .job_valid   (head_valid),
    .job         (head_job),
    .job_pop     (job_pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_success (out_success),
    .out_slot    (out_slot)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ohtab_pkg::*;

  localparam int N              = TABLE_SIZE_DEF;
  localparam int PHASES         = 8;
  localparam int PHASE_REQUESTS = 125;
  localparam int POOL_SIZE      = 32;
  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 400000;

  localparam logic [1:0]           CMD_UNUSED = 2'd3;
  localparam logic [1:0]           PM_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       seq;
  } lookup_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_command;
  logic [KEY_W-1:0]      in_key;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_success;
  logic [SLOT_W-1:0]     out_slot;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [STATUS_W-1:0] model_status [N];
  logic [KEY_W-1:0]    model_keys [N];
  logic [1:0]          model_mode;
  logic [COEF_W-1:0]   model_c1;
  logic [COEF_W-1:0]   model_c2;

  lookup_result_t pending_results[$];
  lookup_result_t head;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int error_count;
  int request_count;
  int cycle_count;
  bit steady;

  open_addressing_hash_table #(.TABLE_SIZE(N)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_success(out_success),
    .out_slot   (out_slot),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int unsigned probe_index(input logic [KEY_W-1:0] key, input int unsigned i);
    longint k, home, stride, c1, c2, ii, sum;
    k = $signed(key);
    ii = i;
    c1 = model_c1;
    c2 = model_c2;
    home = k % N;
    if (home < 0) home += N;
    case (model_mode)
      PM_LINEAR: sum = home + ii;
      PM_QUAD:   sum = home + ((c1 * ii) >> 4) + ((c2 * ii * ii) >> 4);
      PM_DOUBLE: begin
        stride = k % (N - 1);
        if (stride < 0) stride += N - 1;
        sum = home + ii * (stride + 1);
      end
      default:   sum = home;
    endcase
    return int'(sum % N);
  endfunction

  function automatic void apply_to_model(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                                         output logic ok, output logic [SLOT_W-1:0] where);
    int unsigned idx;
    int i;
    bit stop;
    ok = 1'b0;
    where = '0;
    stop = 1'b0;
    if (cmd == CMD_INSERT) begin
      for (i = 0; i < N && !ok; i++) begin
        idx = probe_index(key, i);
        if (model_status[idx] != ST_OCC) begin
          model_keys[idx] = key;
          model_status[idx] = ST_OCC;
          ok = 1'b1;
          where = idx[SLOT_W-1:0];
        end
      end
    end else if (cmd == CMD_SEARCH || cmd == CMD_DELETE) begin
      for (i = 0; i < N && !stop; i++) begin
        idx = probe_index(key, i);
        if (model_status[idx] == ST_EMPTY) begin
          stop = 1'b1;
        end else if (model_status[idx] == ST_OCC && model_keys[idx] == key) begin
          stop = 1'b1;
          ok = 1'b1;
          where = idx[SLOT_W-1:0];
          if (cmd == CMD_DELETE) model_status[idx] = ST_DEL;
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want, input int seq);
    $display("MISMATCH request %0d %s: got %0d, expected %0d", seq, field, got, want);
    error_count++;
  endtask

  task automatic issue_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
    int gap;
    lookup_result_t res;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    do @(posedge clk); while (in_stall);
    apply_to_model(cmd, key, res.success, res.slot);
    res.seq = request_count;
    request_count++;
    pending_results.push_back(res);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PROBE_MODE: model_mode = value[1:0];
      CFG_QUAD_LIN:   model_c1 = value;
      CFG_QUAD_SQ:    model_c2 = value;
      default:        ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_basic_commands;
    issue_request(CMD_INSERT, 32'd0);
    issue_request(CMD_INSERT, 32'd16);
    issue_request(CMD_INSERT, 32'h7FFF_FFFF);
    issue_request(CMD_INSERT, 32'h8000_0000);
    issue_request(CMD_SEARCH, 32'd16);
    issue_request(CMD_SEARCH, 32'h8000_0000);
    issue_request(CMD_DELETE, 32'd16);
    issue_request(CMD_SEARCH, 32'h8000_0000);
    issue_request(CMD_INSERT, 32'd48);
    issue_request(CMD_INSERT, 32'd0);
    issue_request(CMD_SEARCH, 32'd5);
    issue_request(CMD_DELETE, 32'd5);
    issue_request(CMD_UNUSED, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_probe_modes;
    write_register(CFG_PROBE_MODE, PM_QUAD);
    issue_request(CMD_INSERT, 32'd64);
    issue_request(CMD_INSERT, 32'hFFFF_FFFF);
    drain();
    write_register(CFG_PROBE_MODE, PM_DOUBLE);
    issue_request(CMD_INSERT, 32'hFFFF_FFF0);
    issue_request(CMD_SEARCH, 32'hFFFF_FFF0);
    drain();
  endtask

  task automatic test_unused_probe_mode;
    write_register(CFG_PROBE_MODE, PM_UNUSED);
    issue_request(CMD_INSERT, 32'd7);
    issue_request(CMD_INSERT, 32'd23);
    issue_request(CMD_SEARCH, 32'd23);
    issue_request(CMD_DELETE, 32'd7);
    drain();
  endtask

  task automatic test_coefficient_extremes;
    write_register(CFG_PROBE_MODE, PM_QUAD);
    write_register(CFG_QUAD_LIN, 8'd0);
    write_register(CFG_QUAD_SQ, 8'd0);
    issue_request(CMD_INSERT, 32'd0);
    drain();
    write_register(CFG_QUAD_LIN, 8'hFF);
    write_register(CFG_QUAD_SQ, 8'hFF);
    issue_request(CMD_INSERT, 32'd0);
    drain();
    write_register(CFG_UNUSED, 8'hFF);
    issue_request(CMD_SEARCH, 32'd0);
    drain();
  endtask

  task automatic test_random_traffic;
    int phase;
    int n;
    int r;
    int insert_weight;
    logic [1:0] cmd;
    logic [KEY_W-1:0] key;
    for (n = 0; n < POOL_SIZE; n++) begin
      key = $urandom;
      if (n % 2 == 0) key = {key[KEY_W-1:4], 2'b00, 2'(n % 4)};
      key_pool[n] = key;
    end
    for (phase = 0; phase < PHASES; phase++) begin
      steady = (phase == 5);
      if (phase < 4) write_register(CFG_PROBE_MODE, 2'(phase));
      else write_register(CFG_PROBE_MODE, $urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : PM_UNUSED);
      case (phase)
        0:       begin write_register(CFG_QUAD_LIN, 8'd0);  write_register(CFG_QUAD_SQ, 8'hFF); end
        1:       begin write_register(CFG_QUAD_LIN, 8'hFF); write_register(CFG_QUAD_SQ, 8'd0);  end
        default: begin write_register(CFG_QUAD_LIN, $urandom); write_register(CFG_QUAD_SQ, $urandom); end
      endcase
      if ($urandom_range(0, 3) == 0) write_register(CFG_UNUSED, $urandom);
      insert_weight = $urandom_range(20, 55);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        r = $urandom_range(0, 99);
        if (r < insert_weight) cmd = CMD_INSERT;
        else if (r < insert_weight + 25) cmd = CMD_SEARCH;
        else if (r < 97) cmd = CMD_DELETE;
        else cmd = CMD_UNUSED;
        key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
        issue_request(cmd, key);
      end
      drain();
    end
    steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending", out_slot, 0, -1);
      end else begin
        head = pending_results.pop_front();
        if (out_success !== head.success)
          report_mismatch("success", out_success, head.success, head.seq);
        if (out_slot !== head.slot)
          report_mismatch("slot", out_slot, head.slot, head.seq);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stall_driver
    int n;
    forever begin
      n = steady ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    int i;
    error_count   = 0;
    request_count = 0;
    cycle_count   = 0;
    steady        = 1'b0;
    for (i = 0; i < N; i++) begin
      model_status[i] = ST_EMPTY;
      model_keys[i]   = '0;
    end
    model_mode = PM_LINEAR;
    model_c1   = 8'd8;
    model_c2   = 8'd8;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_INSERT;
    in_key     <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_PROBE_MODE;
    cfg_wdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    test_basic_commands();
    test_probe_modes();
    test_unused_probe_mode();
    test_coefficient_extremes();
    test_random_traffic();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ohtab_pkg.sv
design/ohtab_ram.sv
design/ohtab_fifo.sv
design/ohtab_front.sv
design/ohtab_back.sv
design/open_addressing_hash_table.sv
tb/testbench.sv
